[src/lcd4_pkg.sv]
`default_nettype none

package lcd4_pkg;

	localparam logic [2:0] ACT_INIT    = 3'd0;
	localparam logic [2:0] ACT_COMMAND = 3'd1;
	localparam logic [2:0] ACT_DATA    = 3'd2;
	localparam logic [2:0] ACT_CURSOR  = 3'd3;
	localparam logic [2:0] ACT_CLEAR   = 3'd4;

	localparam logic [7:0] CURSOR_BASE = 8'h80;
	localparam logic [7:0] ROW1_OFFSET = 8'h40;

	typedef struct packed {
		logic [2:0] action;
		logic [7:0] byte_value;
		logic [5:0] column;
		logic [1:0] row;
	} req_t;

	typedef struct packed {
		logic        rs_level;
		logic [3:0]  nibble;
		logic        enable_level;
		logic [15:0] hold_us;
		logic        last;
	} step_t;

	typedef enum logic [1:0] {
		RS_KEEP,
		RS_ZERO,
		RS_REQ
	} rs_sel_t;

	typedef enum logic [1:0] {
		NIB_CONST,
		NIB_HIGH,
		NIB_LOW
	} nib_sel_t;

	typedef enum logic [2:0] {
		HOLD_1,
		HOLD_100,
		HOLD_150,
		HOLD_2000,
		HOLD_5000,
		HOLD_50000
	} hold_t;

	localparam int unsigned PC_W = 6;
	typedef logic [PC_W-1:0] pc_t;

	localparam pc_t PC_BYTE  = 6'd0;
	localparam pc_t PC_INIT  = 6'd6;
	localparam pc_t PC_CLEAR = 6'd46;
	localparam pc_t PC_END   = 6'd52;

	typedef struct packed {
		logic       wait_only;
		rs_sel_t    rs_sel;
		nib_sel_t   nib_sel;
		logic [3:0] nib_const;
		logic       enable;
		hold_t      hold;
		logic       last;
		logic       loop;
	} cw_t;

	function automatic logic [15:0] hold_value(hold_t h);
		logic [15:0] v;
		begin
			case (h)
				HOLD_1:     v = 16'd1;
				HOLD_100:   v = 16'd100;
				HOLD_150:   v = 16'd150;
				HOLD_2000:  v = 16'd2000;
				HOLD_5000:  v = 16'd5000;
				HOLD_50000: v = 16'd50000;
				default:    v = 16'd1;
			endcase
			return v;
		end
	endfunction

	function automatic cw_t uc_wait(hold_t h, logic last, logic loop);
		cw_t w;
		begin
			w.wait_only = 1'b1;
			w.rs_sel    = RS_KEEP;
			w.nib_sel   = NIB_CONST;
			w.nib_const = 4'h0;
			w.enable    = 1'b0;
			w.hold      = h;
			w.last      = last;
			w.loop      = loop;
			return w;
		end
	endfunction

	function automatic cw_t uc_strobe(rs_sel_t rs, nib_sel_t ns, logic [3:0] k,
			logic [1:0] phase);
		cw_t w;
		begin
			w.wait_only = 1'b0;
			w.rs_sel    = rs;
			w.nib_sel   = ns;
			w.nib_const = k;
			w.last      = 1'b0;
			w.loop      = 1'b0;
			case (phase)
				2'd0: begin
					w.enable = 1'b0;
					w.hold   = HOLD_1;
				end
				2'd1: begin
					w.enable = 1'b1;
					w.hold   = HOLD_1;
				end
				default: begin
					w.enable = 1'b0;
					w.hold   = HOLD_100;
				end
			endcase
			return w;
		end
	endfunction

	// Microcode store. The byte routine serves commands, data and cursor moves;
	// initialisation falls through into the clear routine, which runs twice.
	function automatic cw_t ucode(pc_t pc);
		cw_t w;
		begin
			w = uc_wait(HOLD_1, 1'b1, 1'b0);
			case (pc)
				6'd0:  w = uc_strobe(RS_REQ, NIB_HIGH, 4'h0, 2'd0);
				6'd1:  w = uc_strobe(RS_REQ, NIB_HIGH, 4'h0, 2'd1);
				6'd2:  w = uc_strobe(RS_REQ, NIB_HIGH, 4'h0, 2'd2);
				6'd3:  w = uc_strobe(RS_REQ, NIB_LOW, 4'h0, 2'd0);
				6'd4:  w = uc_strobe(RS_REQ, NIB_LOW, 4'h0, 2'd1);
				6'd5: begin
					w = uc_strobe(RS_REQ, NIB_LOW, 4'h0, 2'd2);
					w.last = 1'b1;
				end
				6'd6:  w = uc_wait(HOLD_50000, 1'b0, 1'b0);
				6'd7:  w = uc_strobe(RS_KEEP, NIB_CONST, 4'h3, 2'd0);
				6'd8:  w = uc_strobe(RS_KEEP, NIB_CONST, 4'h3, 2'd1);
				6'd9:  w = uc_strobe(RS_KEEP, NIB_CONST, 4'h3, 2'd2);
				6'd10: w = uc_wait(HOLD_5000, 1'b0, 1'b0);
				6'd11: w = uc_strobe(RS_KEEP, NIB_CONST, 4'h3, 2'd0);
				6'd12: w = uc_strobe(RS_KEEP, NIB_CONST, 4'h3, 2'd1);
				6'd13: w = uc_strobe(RS_KEEP, NIB_CONST, 4'h3, 2'd2);
				6'd14: w = uc_wait(HOLD_150, 1'b0, 1'b0);
				6'd15: w = uc_strobe(RS_KEEP, NIB_CONST, 4'h3, 2'd0);
				6'd16: w = uc_strobe(RS_KEEP, NIB_CONST, 4'h3, 2'd1);
				6'd17: w = uc_strobe(RS_KEEP, NIB_CONST, 4'h3, 2'd2);
				6'd18: w = uc_strobe(RS_KEEP, NIB_CONST, 4'h2, 2'd0);
				6'd19: w = uc_strobe(RS_KEEP, NIB_CONST, 4'h2, 2'd1);
				6'd20: w = uc_strobe(RS_KEEP, NIB_CONST, 4'h2, 2'd2);
				6'd21: w = uc_strobe(RS_ZERO, NIB_CONST, 4'h2, 2'd0);
				6'd22: w = uc_strobe(RS_ZERO, NIB_CONST, 4'h2, 2'd1);
				6'd23: w = uc_strobe(RS_ZERO, NIB_CONST, 4'h2, 2'd2);
				6'd24: w = uc_strobe(RS_ZERO, NIB_CONST, 4'h8, 2'd0);
				6'd25: w = uc_strobe(RS_ZERO, NIB_CONST, 4'h8, 2'd1);
				6'd26: w = uc_strobe(RS_ZERO, NIB_CONST, 4'h8, 2'd2);
				6'd27: w = uc_strobe(RS_ZERO, NIB_CONST, 4'h0, 2'd0);
				6'd28: w = uc_strobe(RS_ZERO, NIB_CONST, 4'h0, 2'd1);
				6'd29: w = uc_strobe(RS_ZERO, NIB_CONST, 4'h0, 2'd2);
				6'd30: w = uc_strobe(RS_ZERO, NIB_CONST, 4'hC, 2'd0);
				6'd31: w = uc_strobe(RS_ZERO, NIB_CONST, 4'hC, 2'd1);
				6'd32: w = uc_strobe(RS_ZERO, NIB_CONST, 4'hC, 2'd2);
				6'd33: w = uc_strobe(RS_ZERO, NIB_CONST, 4'h0, 2'd0);
				6'd34: w = uc_strobe(RS_ZERO, NIB_CONST, 4'h0, 2'd1);
				6'd35: w = uc_strobe(RS_ZERO, NIB_CONST, 4'h0, 2'd2);
				6'd36: w = uc_strobe(RS_ZERO, NIB_CONST, 4'h6, 2'd0);
				6'd37: w = uc_strobe(RS_ZERO, NIB_CONST, 4'h6, 2'd1);
				6'd38: w = uc_strobe(RS_ZERO, NIB_CONST, 4'h6, 2'd2);
				6'd39: w = uc_strobe(RS_ZERO, NIB_CONST, 4'h0, 2'd0);
				6'd40: w = uc_strobe(RS_ZERO, NIB_CONST, 4'h0, 2'd1);
				6'd41: w = uc_strobe(RS_ZERO, NIB_CONST, 4'h0, 2'd2);
				6'd42: w = uc_strobe(RS_ZERO, NIB_CONST, 4'h1, 2'd0);
				6'd43: w = uc_strobe(RS_ZERO, NIB_CONST, 4'h1, 2'd1);
				6'd44: w = uc_strobe(RS_ZERO, NIB_CONST, 4'h1, 2'd2);
				6'd45: w = uc_wait(HOLD_5000, 1'b0, 1'b0);
				6'd46: w = uc_strobe(RS_ZERO, NIB_CONST, 4'h0, 2'd0);
				6'd47: w = uc_strobe(RS_ZERO, NIB_CONST, 4'h0, 2'd1);
				6'd48: w = uc_strobe(RS_ZERO, NIB_CONST, 4'h0, 2'd2);
				6'd49: w = uc_strobe(RS_ZERO, NIB_CONST, 4'h1, 2'd0);
				6'd50: w = uc_strobe(RS_ZERO, NIB_CONST, 4'h1, 2'd1);
				6'd51: w = uc_strobe(RS_ZERO, NIB_CONST, 4'h1, 2'd2);
				6'd52: w = uc_wait(HOLD_2000, 1'b1, 1'b1);
				default: w = uc_wait(HOLD_1, 1'b1, 1'b0);
			endcase
			return w;
		end
	endfunction

endpackage

`default_nettype wire

[src/char_lcd_4bit_interface_sequencer.sv]
`default_nettype none

// Four-bit character LCD sequencer. Each request (initialise, command byte,
// data byte, cursor move or clear) becomes a run of pin steps, one step per
// clock while the step channel is not stalled: 6 steps for a byte or cursor
// move, 14 for a clear and 54 for the initialisation, the last one marked.
// The rate is set by a step counter walking a microcode store, one control
// word per step. A new request is taken on the clock after the final step of
// the previous run has entered the output register; actions 5 to 7 are
// accepted but give no steps. Each step carries the hold time in
// microseconds for the host to time.

module char_lcd_4bit_interface_sequencer (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            req_valid,
	output logic            req_stall,
	input  lcd4_pkg::req_t  req_data,
	output logic            step_valid,
	input  logic            step_stall,
	output lcd4_pkg::step_t step_data
);
	import lcd4_pkg::*;

	logic       busy_q;
	logic       pass_q;
	pc_t        pc_q;
	logic [7:0] byte_q;
	logic       rs_req_q;
	logic       step_valid_q;
	step_t      step_q;

	cw_t        cw;
	logic       accept;
	logic       emit;
	logic       take_jump;
	logic       end_run;
	logic       known;
	pc_t        entry;
	logic [7:0] cursor_off;
	logic [7:0] cursor_addr;
	step_t      next_step;

	assign req_stall  = busy_q;
	assign accept     = req_valid && !busy_q;
	assign cw         = ucode(pc_q);
	assign emit       = busy_q && (!step_valid_q || !step_stall);
	assign take_jump  = cw.loop && !pass_q;
	assign end_run    = cw.last && !take_jump;
	assign step_valid = step_valid_q;
	assign step_data  = step_q;

	assign cursor_off  = (req_data.row == 2'd0) ? 8'h00 : ROW1_OFFSET;
	assign cursor_addr = CURSOR_BASE | ({2'b00, req_data.column} + cursor_off);

	always_comb begin
		known = 1'b1;
		entry = PC_BYTE;
		case (req_data.action)
			ACT_INIT:    entry = PC_INIT;
			ACT_CLEAR:   entry = PC_CLEAR;
			ACT_COMMAND: entry = PC_BYTE;
			ACT_DATA:    entry = PC_BYTE;
			ACT_CURSOR:  entry = PC_BYTE;
			default:     known = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			pass_q <= 1'b0;
			pc_q   <= PC_BYTE;
		end else if (accept) begin
			busy_q <= known;
			pass_q <= 1'b0;
			pc_q   <= entry;
		end else if (emit) begin
			if (end_run) begin
				busy_q <= 1'b0;
			end else if (take_jump) begin
				pc_q   <= PC_CLEAR;
				pass_q <= 1'b1;
			end else begin
				pc_q <= pc_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			byte_q   <= (req_data.action == ACT_CURSOR) ? cursor_addr : req_data.byte_value;
			rs_req_q <= (req_data.action == ACT_DATA);
		end
	end

	lcd4_pins u_pins (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (emit),
		.cw       (cw),
		.req_rs   (rs_req_q),
		.req_byte (byte_q),
		.last     (end_run),
		.step     (next_step)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_valid_q <= 1'b0;
		end else if (emit) begin
			step_valid_q <= 1'b1;
		end else if (!step_stall) begin
			step_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			step_q <= next_step;
		end
	end

	a_run_ends: assert property (@(posedge clk) disable iff (!arst_n)
		emit && end_run |=> !busy_q)
		else $error("sequencer still busy after the final step");

	a_pc_range: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> pc_q <= PC_END)
		else $error("step counter outside the program");

	a_unknown: assert property (@(posedge clk) disable iff (!arst_n)
		accept && !known |=> !busy_q)
		else $error("unknown action started a run");

	a_strobe_short: assert property (@(posedge clk) disable iff (!arst_n)
		step_valid_q && step_q.enable_level |-> step_q.hold_us == 16'd1)
		else $error("enable high for longer than one microsecond");

	a_last_low: assert property (@(posedge clk) disable iff (!arst_n)
		step_valid_q && step_q.last |-> !step_q.enable_level)
		else $error("run ended with enable high");

endmodule

`default_nettype wire

[src/lcd4_pins.sv]
`default_nettype none

module lcd4_pins (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            load,
	input  lcd4_pkg::cw_t   cw,
	input  logic            req_rs,
	input  logic [7:0]      req_byte,
	input  logic            last,
	output lcd4_pkg::step_t step
);
	import lcd4_pkg::*;

	logic       rs_q;
	logic [3:0] data_q;
	logic       en_q;
	logic       rs_n;
	logic [3:0] nib_n;
	logic       en_n;

	always_comb begin
		rs_n  = rs_q;
		nib_n = data_q;
		en_n  = en_q;
		if (!cw.wait_only) begin
			case (cw.rs_sel)
				RS_ZERO: rs_n = 1'b0;
				RS_REQ:  rs_n = req_rs;
				default: rs_n = rs_q;
			endcase
			case (cw.nib_sel)
				NIB_HIGH: nib_n = req_byte[7:4];
				NIB_LOW:  nib_n = req_byte[3:0];
				default:  nib_n = cw.nib_const;
			endcase
			en_n = cw.enable;
		end
	end

	always_comb begin
		step.rs_level     = rs_n;
		step.nibble       = nib_n;
		step.enable_level = en_n;
		step.hold_us      = hold_value(cw.hold);
		step.last         = last;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rs_q   <= 1'b0;
			data_q <= 4'h0;
			en_q   <= 1'b0;
		end else if (load) begin
			rs_q   <= rs_n;
			data_q <= nib_n;
			en_q   <= en_n;
		end
	end

endmodule

`default_nettype wire

[sim/char_lcd_4bit_interface_sequencer_tb.sv]
`default_nettype none

module char_lcd_4bit_interface_sequencer_tb;

	import lcd4_pkg::*;

	localparam logic [2:0] ACT_UNKNOWN_FIRST = 3'd5;
	localparam logic [2:0] ACT_UNKNOWN_LAST  = 3'd7;
	localparam int         HOLD_OFF_CYCLES   = 200;
	localparam int         DRAIN_CYCLES      = 16;
	localparam int         LIMIT_CYCLES      = 400000;

	logic  clk        = 1'b0;
	logic  arst_n     = 1'b0;
	logic  req_valid  = 1'b0;
	logic  req_stall;
	req_t  req_data   = '0;
	logic  step_valid;
	logic  step_stall = 1'b0;
	step_t step_data;

	char_lcd_4bit_interface_sequencer u_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.req_valid  (req_valid),
		.req_stall  (req_stall),
		.req_data   (req_data),
		.step_valid (step_valid),
		.step_stall (step_stall),
		.step_data  (step_data)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Pin levels last driven towards the display, as the sequencer sees them.
	logic       pin_rs   = 1'b0;
	logic [3:0] pin_data = 4'h0;
	logic       pin_en   = 1'b0;

	step_t run_steps[$];
	step_t lcd_steps_due[$];
	step_t due_step;

	int    mismatch_count   = 0;
	int    steps_checked    = 0;
	int    sent_count[8]    = '{default: 0};
	bit    idle_on          = 1'b0;
	bit    hold_off_pending = 1'b0;

	task automatic drive_pins(input logic rs, input logic [3:0] nib, input logic en,
			input logic [15:0] hold);
		step_t s;
		pin_rs         = rs;
		pin_data       = nib;
		pin_en         = en;
		s.rs_level     = rs;
		s.nibble       = nib;
		s.enable_level = en;
		s.hold_us      = hold;
		s.last         = 1'b0;
		run_steps.push_back(s);
	endtask

	task automatic hold_pins(input logic [15:0] hold);
		drive_pins(pin_rs, pin_data, pin_en, hold);
	endtask

	task automatic strobe_nibble(input logic [3:0] nib);
		drive_pins(pin_rs, nib, 1'b0, 16'd1);
		drive_pins(pin_rs, nib, 1'b1, 16'd1);
		drive_pins(pin_rs, nib, 1'b0, 16'd100);
	endtask

	task automatic write_byte(input logic [7:0] b, input logic rs);
		pin_rs = rs;
		strobe_nibble(b[7:4]);
		strobe_nibble(b[3:0]);
	endtask

	task automatic clear_display();
		write_byte(8'h01, 1'b0);
		hold_pins(16'd2000);
		write_byte(8'h01, 1'b0);
		hold_pins(16'd2000);
	endtask

	task automatic predict_lcd_run(input req_t r);
		logic [7:0] addr;
		step_t      tail;
		run_steps.delete();
		case (r.action)
			ACT_INIT: begin
				hold_pins(16'd50000);
				strobe_nibble(4'h3);
				hold_pins(16'd5000);
				strobe_nibble(4'h3);
				hold_pins(16'd150);
				strobe_nibble(4'h3);
				strobe_nibble(4'h2);
				write_byte(8'h28, 1'b0);
				write_byte(8'h0C, 1'b0);
				write_byte(8'h06, 1'b0);
				write_byte(8'h01, 1'b0);
				hold_pins(16'd5000);
				clear_display();
			end
			ACT_COMMAND: write_byte(r.byte_value, 1'b0);
			ACT_DATA: write_byte(r.byte_value, 1'b1);
			ACT_CURSOR: begin
				addr = CURSOR_BASE |
					({2'b00, r.column} + ((r.row == 2'd0) ? 8'h00 : ROW1_OFFSET));
				write_byte(addr, 1'b0);
			end
			ACT_CLEAR: clear_display();
			default: ;
		endcase
		if (run_steps.size() > 0) begin
			tail = run_steps.pop_back();
			tail.last = 1'b1;
			run_steps.push_back(tail);
		end
		foreach (run_steps[i])
			lcd_steps_due.push_back(run_steps[i]);
	endtask

	function automatic req_t make_req(input logic [2:0] act, input logic [7:0] b,
			input logic [5:0] col, input logic [1:0] rw);
		req_t r;
		r.action     = act;
		r.byte_value = b;
		r.column     = col;
		r.row        = rw;
		return r;
	endfunction

	task automatic send_request(input req_t r);
		int gap;
		gap = (idle_on && $urandom_range(0, 3) == 0) ? $urandom_range(1, 6) : 0;
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_valid <= 1'b1;
		req_data  <= r;
		do @(posedge clk); while (req_stall);
		predict_lcd_run(r);
		sent_count[r.action]++;
	endtask

	task automatic report_mismatch(input string what, input logic [15:0] got,
			input logic [15:0] want);
		$display("mismatch at step %0d: %s is %0h, %0h was due", steps_checked, what, got, want);
		mismatch_count++;
	endtask

	always @(posedge clk) begin
		if (arst_n && step_valid && !step_stall) begin
			if (lcd_steps_due.size() == 0) begin
				report_mismatch("step with nothing due, hold_us", step_data.hold_us, 16'h0);
			end else begin
				due_step = lcd_steps_due.pop_front();
				if (step_data.rs_level !== due_step.rs_level)
					report_mismatch("rs_level", 16'(step_data.rs_level),
						16'(due_step.rs_level));
				if (step_data.nibble !== due_step.nibble)
					report_mismatch("nibble", 16'(step_data.nibble), 16'(due_step.nibble));
				if (step_data.enable_level !== due_step.enable_level)
					report_mismatch("enable_level", 16'(step_data.enable_level),
						16'(due_step.enable_level));
				if (step_data.hold_us !== due_step.hold_us)
					report_mismatch("hold_us", step_data.hold_us, due_step.hold_us);
				if (step_data.last !== due_step.last)
					report_mismatch("last", 16'(step_data.last), 16'(due_step.last));
			end
			steps_checked++;
		end
	end

	initial begin
		wait (arst_n);
		forever begin
			@(posedge clk);
			if (hold_off_pending) begin
				hold_off_pending = 1'b0;
				step_stall <= 1'b1;
				repeat (HOLD_OFF_CYCLES) @(posedge clk);
				step_stall <= 1'b0;
			end else if (idle_on && $urandom_range(0, 7) == 0) begin
				step_stall <= 1'b1;
				repeat ($urandom_range(1, 6)) @(posedge clk);
				step_stall <= 1'b0;
			end
		end
	end

	task automatic test_directed_runs();
		int a;
		send_request(make_req(ACT_INIT, 8'h00, 6'd0, 2'd0));
		send_request(make_req(ACT_COMMAND, 8'h00, 6'd0, 2'd0));
		send_request(make_req(ACT_COMMAND, 8'hFF, 6'd63, 2'd3));
		send_request(make_req(ACT_DATA, 8'h00, 6'd0, 2'd0));
		send_request(make_req(ACT_DATA, 8'hFF, 6'd0, 2'd0));
		send_request(make_req(ACT_DATA, 8'h5A, 6'd21, 2'd1));
		// Initialisation straight after data keeps the data register select on its nibbles.
		send_request(make_req(ACT_INIT, 8'hFF, 6'd63, 2'd3));
		send_request(make_req(ACT_CURSOR, 8'h00, 6'd0, 2'd0));
		send_request(make_req(ACT_CURSOR, 8'h00, 6'd39, 2'd1));
		send_request(make_req(ACT_CURSOR, 8'hFF, 6'd63, 2'd3));
		send_request(make_req(ACT_CURSOR, 8'h00, 6'd63, 2'd0));
		send_request(make_req(ACT_CURSOR, 8'h00, 6'd0, 2'd2));
		send_request(make_req(ACT_CURSOR, 8'hAA, 6'd40, 2'd2));
		send_request(make_req(ACT_CLEAR, 8'h00, 6'd0, 2'd0));
		for (a = ACT_UNKNOWN_FIRST; a <= ACT_UNKNOWN_LAST; a++)
			send_request(make_req(a[2:0], 8'hFF, 6'd63, 2'd3));
		send_request(make_req(ACT_DATA, 8'hC3, 6'd0, 2'd0));
		send_request(make_req(ACT_CLEAR, 8'hFF, 6'd63, 2'd3));
	endtask

	task automatic test_output_backpressure();
		int i;
		idle_on = 1'b0;
		hold_off_pending = 1'b1;
		for (i = 0; i < 12; i++)
			send_request(make_req(ACT_DATA, 8'($urandom_range(0, 255)),
				6'($urandom_range(0, 63)), 2'($urandom_range(0, 3))));
		idle_on = 1'b1;
	endtask

	task automatic test_random_mix(input int n);
		int         counted;
		int         pick;
		logic [2:0] act;
		counted = 0;
		while (counted < n) begin
			pick = $urandom_range(0, 99);
			if (pick < 4)
				act = ACT_INIT;
			else if (pick < 14)
				act = ACT_CLEAR;
			else if (pick < 36)
				act = ACT_COMMAND;
			else if (pick < 64)
				act = ACT_DATA;
			else if (pick < 92)
				act = ACT_CURSOR;
			else
				act = 3'($urandom_range(ACT_UNKNOWN_FIRST, ACT_UNKNOWN_LAST));
			send_request(make_req(act, 8'($urandom_range(0, 255)),
				6'($urandom_range(0, 63)), 2'($urandom_range(0, 3))));
			if (act < ACT_UNKNOWN_FIRST)
				counted++;
		end
	endtask

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		idle_on = 1'b1;
		test_directed_runs();
		test_output_backpressure();
		test_random_mix(150);
		idle_on = 1'b0;
		test_random_mix(40);
		req_valid <= 1'b0;
		while (lcd_steps_due.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("Covered %0d initialise, %0d command, %0d data, %0d cursor, %0d clear",
			sent_count[ACT_INIT], sent_count[ACT_COMMAND], sent_count[ACT_DATA],
			sent_count[ACT_CURSOR], sent_count[ACT_CLEAR]);
		$display("and %0d unknown requests; checked %0d pin steps with %0d mismatches.",
			sent_count[5] + sent_count[6] + sent_count[7], steps_checked, mismatch_count);
		if (mismatch_count == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

	initial begin
		#(20 * LIMIT_CYCLES);
		$display("Timed out with %0d pin steps still due.", lcd_steps_due.size());
		$display("FAIL");
		$finish;
	end

endmodule

`default_nettype wire
